@@ rtl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg - shared types and constants of the I2C master transfer sequencer
// Command, status and action codes, the queued operation and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    // Transmit buffer geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int BUF_AW       = $clog2(BUFFER_DEPTH);

    // Field widths
    localparam int IDX_W  = 4;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;
    localparam int EV_W   = 4;

    // Largest legal transfer length
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(BUFFER_DEPTH);

    // Operation queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int S_TUSER_W = 2;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_IDLE        = 4'd0,
        EV_START       = 4'd1,
        EV_REP_START   = 4'd2,
        EV_SLAW_ACK    = 4'd3,
        EV_SLAW_NACK   = 4'd4,
        EV_DATAW_ACK   = 4'd5,
        EV_DATAW_NACK  = 4'd6,
        EV_ARB_LOST    = 4'd7,
        EV_SLAR_ACK    = 4'd8,
        EV_SLAR_NACK   = 4'd9,
        EV_DATAR_ACK   = 4'd10,
        EV_DATAR_NACK  = 4'd11,
        EV_OTHER       = 4'd12
    } status_ev_t;

    typedef enum logic [1:0] {
        RPL_OK      = 2'd0,
        RPL_BAD_LEN = 2'd1,
        RPL_BUSY    = 2'd2,
        RPL_OFF     = 2'd3
    } reply_t;

    typedef enum logic [1:0] {
        SA_NONE  = 2'd0,
        SA_START = 2'd1,
        SA_CLEAR = 2'd2
    } start_act_t;

    typedef enum logic [1:0] {
        ACK_KEEP = 2'd0,
        ACK_ON   = 2'd1,
        ACK_OFF  = 2'd2
    } ack_act_t;

    typedef enum logic [1:0] {
        OUTC_UNKNOWN = 2'd0,
        OUTC_OK      = 2'd1,
        OUTC_FAIL    = 2'd2
    } outcome_t;

    // Classified operation, as queued from front to back
    typedef struct packed {
        cmd_t              kind;
        logic [IDX_W-1:0]  tx_index;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] slave_addr;
        logic [LEN_W-1:0]  tx_len;
        logic [LEN_W-1:0]  rx_len;
        status_ev_t        status_ev;
        logic              len_bad;
        logic              load_ok;
    } op_t;

    // One result beat
    typedef struct packed {
        reply_t            reply_code;
        logic              data_out_valid;
        logic [BYTE_W-1:0] data_out;
        start_act_t        start_action;
        logic              stop_request;
        ack_act_t          ack_action;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic [IDX_W-1:0]  rx_index;
        logic              busy_res;
        outcome_t          tx_outcome;
        outcome_t          rx_outcome;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/i2cms_front.sv @@
// ----------------------------------------------------------------------------
// i2cms_front - input stage of the I2C master transfer sequencer
// Accepts input beats, unpacks and classifies them, and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_front
    import i2cms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output op_t                       push_op
);

    logic stg_valid_reg;
    logic stg_valid_next;
    op_t  stg_op_reg;
    op_t  dec_op;
    logic take;

    // Unpack and classify the incoming beat
    always_comb
    begin
        dec_op.kind       = cmd_t'(s_tuser[1:0]);
        dec_op.tx_index   = s_tdata[3:0];
        dec_op.data_byte  = s_tdata[11:4];
        dec_op.slave_addr = s_tdata[19:12];
        dec_op.tx_len     = s_tdata[24:20];
        dec_op.rx_len     = s_tdata[29:25];
        dec_op.status_ev  = status_ev_t'(s_tdata[33:30]);
        dec_op.len_bad    = ((s_tdata[24:20] == '0) && (s_tdata[29:25] == '0))
                            || (s_tdata[24:20] > LEN_MAX)
                            || (s_tdata[29:25] > LEN_MAX);
        dec_op.load_ok    = (LEN_W'(s_tdata[3:0]) < LEN_MAX);
    end

    // Take a beat when the stage is empty or drains this cycle
    assign s_tready   = !stg_valid_reg || push_ready;
    assign take       = s_tvalid && s_tready;
    assign push_valid = stg_valid_reg;
    assign push_op    = stg_op_reg;

    always_comb
    begin
        stg_valid_next = take || (stg_valid_reg && !push_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
        end
    end

    // Hold the classified operation
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_op_reg <= dec_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/i2cms_queue.sv @@
// ----------------------------------------------------------------------------
// i2cms_queue - operation queue of the I2C master transfer sequencer
// Short register FIFO that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_queue
    import i2cms_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire op_t  push_op,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output op_t       pop_op
);

    op_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed operation
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

@@ rtl/i2cms_back.sv @@
// ----------------------------------------------------------------------------
// i2cms_back - execution stage of the I2C master transfer sequencer
// Carries out queued operations against the transfer state, one per cycle
// unless the output stalls, and registers each result beat for m_tdata.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_back
    import i2cms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 bus_enabled,
    input  wire logic                 pop_valid,
    output logic                      pop_ready,
    input  wire op_t                  pop_op,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic              busy_reg,   busy_next;
    logic [BYTE_W-1:0] addr_reg,   addr_next;
    logic [LEN_W-1:0]  wleft_reg,  wleft_next;
    logic [LEN_W-1:0]  wcnt_reg,   wcnt_next;
    logic [LEN_W-1:0]  rlen_reg,   rlen_next;
    logic [LEN_W-1:0]  rcnt_reg,   rcnt_next;
    outcome_t          wres_reg,   wres_next;
    outcome_t          rres_reg,   rres_next;
    logic              out_valid_reg, out_valid_next;
    res_t              res_reg;
    res_t              res_next;
    logic [BYTE_W-1:0] wbuf_reg [BUFFER_DEPTH];

    logic              take;
    logic              wr_more;
    logic              rx_take;
    logic [LEN_W-1:0]  rcnt_after;
    logic [BYTE_W-1:0] wbuf_rd;

    // Execute when the output register is free or drains this cycle
    assign pop_ready = !out_valid_reg || m_tready;
    assign take      = pop_valid && pop_ready;

    assign wr_more    = (wcnt_reg < wleft_reg) && (wcnt_reg < LEN_MAX);
    assign wbuf_rd    = wbuf_reg[wcnt_reg[BUF_AW-1:0]];
    assign rx_take    = (rcnt_reg < rlen_reg);
    assign rcnt_after = rcnt_reg + LEN_W'(rx_take);

    // Decide the controller action and the next transfer state
    always_comb
    begin
        busy_next  = busy_reg;
        addr_next  = addr_reg;
        wleft_next = wleft_reg;
        wcnt_next  = wcnt_reg;
        rlen_next  = rlen_reg;
        rcnt_next  = rcnt_reg;
        wres_next  = wres_reg;
        rres_next  = rres_reg;

        res_next                = '0;
        res_next.reply_code     = RPL_OK;
        res_next.start_action   = SA_NONE;
        res_next.ack_action     = ACK_KEEP;

        case (pop_op.kind)
            CMD_START:
            begin
                if (pop_op.len_bad)
                begin
                    res_next.reply_code = RPL_BAD_LEN;
                end
                else if (busy_reg)
                begin
                    res_next.reply_code = RPL_BUSY;
                end
                else if (!bus_enabled)
                begin
                    res_next.reply_code = RPL_OFF;
                end
                else
                begin
                    busy_next  = 1'b1;
                    addr_next  = pop_op.slave_addr;
                    wleft_next = pop_op.tx_len;
                    wcnt_next  = '0;
                    rlen_next  = pop_op.rx_len;
                    rcnt_next  = '0;
                    if (pop_op.tx_len != '0)
                    begin
                        wres_next = OUTC_UNKNOWN;
                    end
                    if (pop_op.rx_len != '0)
                    begin
                        rres_next = OUTC_UNKNOWN;
                    end
                    res_next.start_action = SA_START;
                end
            end
            CMD_EVENT:
            begin
                case (pop_op.status_ev)
                    EV_IDLE:
                    begin
                        res_next.ack_action = ACK_KEEP;
                    end
                    EV_START, EV_REP_START:
                    begin
                        res_next.start_action   = SA_CLEAR;
                        res_next.data_out_valid = 1'b1;
                        res_next.data_out       = {addr_reg[BYTE_W-1:1],
                                                   (wleft_reg == '0)};
                    end
                    EV_SLAW_ACK:
                    begin
                        if (wr_more)
                        begin
                            res_next.data_out_valid = 1'b1;
                            res_next.data_out       = wbuf_rd;
                            wcnt_next               = wcnt_reg + LEN_W'(1);
                        end
                        res_next.ack_action = ACK_ON;
                    end
                    EV_DATAW_ACK:
                    begin
                        if (wr_more)
                        begin
                            res_next.data_out_valid = 1'b1;
                            res_next.data_out       = wbuf_rd;
                            wcnt_next               = wcnt_reg + LEN_W'(1);
                        end
                        else
                        begin
                            // Write phase done: turn around or stop
                            if ((rcnt_reg == '0) && (rlen_reg != '0))
                            begin
                                res_next.start_action = SA_START;
                            end
                            else
                            begin
                                res_next.stop_request = 1'b1;
                                busy_next             = 1'b0;
                            end
                            wleft_next = '0;
                            wres_next  = OUTC_OK;
                        end
                        res_next.ack_action = ACK_ON;
                    end
                    EV_SLAW_NACK, EV_DATAW_NACK:
                    begin
                        res_next.stop_request = 1'b1;
                        res_next.ack_action   = ACK_ON;
                        busy_next             = 1'b0;
                        wleft_next            = '0;
                        wres_next             = OUTC_FAIL;
                    end
                    EV_ARB_LOST:
                    begin
                        res_next.start_action = SA_START;
                        res_next.ack_action   = ACK_ON;
                        busy_next             = 1'b0;
                    end
                    EV_DATAR_ACK:
                    begin
                        if (rx_take)
                        begin
                            res_next.rx_valid = 1'b1;
                            res_next.rx_byte  = pop_op.data_byte;
                            res_next.rx_index = rcnt_reg[IDX_W-1:0];
                        end
                        rcnt_next           = rcnt_after;
                        res_next.ack_action = ((rcnt_after + LEN_W'(1)) < rlen_reg)
                                              ? ACK_ON : ACK_OFF;
                    end
                    EV_SLAR_ACK:
                    begin
                        res_next.ack_action = ((rcnt_reg + LEN_W'(1)) < rlen_reg)
                                              ? ACK_ON : ACK_OFF;
                    end
                    EV_DATAR_NACK:
                    begin
                        if (rx_take)
                        begin
                            res_next.rx_valid = 1'b1;
                            res_next.rx_byte  = pop_op.data_byte;
                            res_next.rx_index = rcnt_reg[IDX_W-1:0];
                        end
                        rcnt_next             = rcnt_after;
                        res_next.stop_request = 1'b1;
                        res_next.ack_action   = ACK_ON;
                        busy_next             = 1'b0;
                        rres_next             = OUTC_OK;
                    end
                    EV_SLAR_NACK:
                    begin
                        res_next.stop_request = 1'b1;
                        res_next.ack_action   = ACK_ON;
                        busy_next             = 1'b0;
                        rres_next             = OUTC_FAIL;
                    end
                    default:
                    begin
                        res_next.stop_request = 1'b1;
                        res_next.ack_action   = ACK_ON;
                        busy_next             = 1'b0;
                    end
                endcase
            end
            default:
            begin
                res_next.reply_code = RPL_OK;
            end
        endcase

        res_next.busy_res   = busy_next;
        res_next.tx_outcome = wres_next;
        res_next.rx_outcome = rres_next;
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = take || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            addr_reg      <= '0;
            wleft_reg     <= '0;
            wcnt_reg      <= '0;
            rlen_reg      <= '0;
            rcnt_reg      <= '0;
            wres_reg      <= OUTC_UNKNOWN;
            rres_reg      <= OUTC_UNKNOWN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                busy_reg  <= busy_next;
                addr_reg  <= addr_next;
                wleft_reg <= wleft_next;
                wcnt_reg  <= wcnt_next;
                rlen_reg  <= rlen_next;
                rcnt_reg  <= rcnt_next;
                wres_reg  <= wres_next;
                rres_reg  <= rres_next;
            end
        end
    end

    // Hold the result beat and load the transmit buffer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
        if (take && (pop_op.kind == CMD_LOAD) && pop_op.load_ok)
        begin
            wbuf_reg[pop_op.tx_index[BUF_AW-1:0]] <= pop_op.data_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       res_reg.rx_outcome,
                       res_reg.tx_outcome,
                       res_reg.busy_res,
                       res_reg.rx_index,
                       res_reg.rx_byte,
                       res_reg.rx_valid,
                       res_reg.ack_action,
                       res_reg.stop_request,
                       res_reg.start_action,
                       res_reg.data_out,
                       res_reg.data_out_valid,
                       res_reg.reply_code};

`ifndef SYNTH
    // Write count never runs past the buffer
    assert property (@(posedge clk) disable iff (!rst_n) wcnt_reg <= LEN_MAX)
        else $error("write count beyond buffer depth");

    // Read count never runs past the read length
    assert property (@(posedge clk) disable iff (!rst_n) rcnt_reg <= rlen_reg)
        else $error("read count beyond read length");

    // An accepted start leaves the sequencer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (pop_op.kind == CMD_START) && (res_next.reply_code == RPL_OK)
        |=> busy_reg)
        else $error("accepted start did not set busy");

    // A stop request always ends the transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        take && res_next.stop_request |=> !busy_reg)
        else $error("stop requested while still busy");
`endif

endmodule

`default_nettype wire

@@ rtl/i2c_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer - I2C master transfer sequencer for one bus
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   tdata: op fields, tuser: cmd
//   m_*       out  m_tvalid/m_tready   tdata: one result beat per input beat
//   cfg_*     in   cfg_wr_en           cfg_wr_data: bus_enabled
//
// One beat per cycle sustained unless the output stalls. Each beat passes the
// input stage, the two-entry queue and the execution stage with its output
// register; the last retires one operation a cycle against the transfer state.
// Reset clears all control state; the transmit buffer holds no reset value.
// Either side may stall independently; the queue absorbs the difference.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // tx_index[3:0], data_byte[11:4], slave_addr[19:12], tx_len[24:20],
    // rx_len[29:25], status_event[33:30], zero pad[39:34]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // reply_code[1:0], data_out_valid[2], data_out[10:3], start_action[12:11],
    // stop_request[13], ack_action[15:14], rx_valid[16], rx_byte[24:17],
    // rx_index[28:25], busy_res[29], tx_outcome[31:30], rx_outcome[33:32],
    // zero pad[39:34]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    logic bus_en_reg;
    logic bus_en_next;
    logic push_valid;
    logic push_ready;
    op_t  push_op;
    logic pop_valid;
    logic pop_ready;
    op_t  pop_op;

    // Hold the bus enable register
    always_comb
    begin
        bus_en_next = cfg_wr_en ? cfg_wr_data : bus_en_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_en_reg <= 1'b0;
        end
        else
        begin
            bus_en_reg <= bus_en_next;
        end
    end

    i2cms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op)
    );

    i2cms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_op     (pop_op)
    );

    i2cms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .bus_enabled (bus_en_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_op      (pop_op),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the I2C master transfer sequencer
// Drives load, start and bus-status beats on the input stream and compares
// every result beat field by field with a table row or a sequencer model.
// It starts with a short table of directed beats, then runs phases of random
// transfers under several sender idle and receiver stall mixes, with the bus
// enable register switched between phases.
// ----------------------------------------------------------------------------
module tb;
    import i2cms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] dbyte;
        logic [BYTE_W-1:0] addr;
        logic [LEN_W-1:0]  tl;
        logic [LEN_W-1:0]  rl;
        logic [EV_W-1:0]   ev;
    } xfer_op_t;

    typedef enum logic [1:0] {
        BUS_KEEP = 2'd0,
        BUS_OFF  = 2'd1,
        BUS_ON   = 2'd2
    } bus_req_t;

    typedef struct packed {
        xfer_op_t op;
        bus_req_t bus;
        logic     typed;
        res_t     want;
    } plan_row_t;

    // DUT ports
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic                 cfg_wr_data = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Sequencer model state
    bit                bus_on;
    bit                busy;
    logic [BYTE_W-1:0] tgt_addr   = '0;
    logic [LEN_W-1:0]  wr_left    = '0;
    logic [LEN_W-1:0]  wr_cnt     = '0;
    logic [LEN_W-1:0]  rd_len     = '0;
    logic [LEN_W-1:0]  rd_cnt     = '0;
    logic [BYTE_W-1:0] tx_buf     [BUFFER_DEPTH];
    bit                tx_written [BUFFER_DEPTH];
    outcome_t          wr_res = OUTC_UNKNOWN;
    outcome_t          rd_res = OUTC_UNKNOWN;

    // Expected result beats, oldest first
    res_t      result_q [$];
    plan_row_t plan [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int fail_count     = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int starts_ok      = 0;
    int rx_delivered   = 0;
    int idle_cycles    = 0;

    i2c_master_transfer_sequencer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #2 clk = ~clk;

    // Stall the result stream at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Hand the next transmit byte to the controller, if one is left
    function automatic void send_next_tx(inout res_t r);
        if (wr_cnt < wr_left && wr_cnt < BUFFER_DEPTH)
        begin
            r.data_out_valid = 1'b1;
            r.data_out       = tx_buf[wr_cnt[IDX_W-1:0]];
            wr_cnt           = wr_cnt + 1'b1;
        end
    endfunction

    // Deliver a received byte unless the read is already complete
    function automatic void deliver_rx(input logic [BYTE_W-1:0] b, inout res_t r);
        if (rd_cnt < rd_len)
        begin
            r.rx_valid = 1'b1;
            r.rx_byte  = b;
            r.rx_index = rd_cnt[IDX_W-1:0];
            rd_cnt     = rd_cnt + 1'b1;
        end
    endfunction

    // Advance the sequencer model by one beat and return its result
    function automatic res_t predict_beat(input xfer_op_t op);
        res_t r;
        r = '0;
        case (op.cmd)
            CMD_LOAD:
            begin
                tx_buf[op.idx]     = op.dbyte;
                tx_written[op.idx] = 1'b1;
            end
            CMD_START:
            begin
                if ((op.tl == 0 && op.rl == 0) || op.tl > LEN_MAX || op.rl > LEN_MAX)
                    r.reply_code = RPL_BAD_LEN;
                else if (busy)
                    r.reply_code = RPL_BUSY;
                else if (!bus_on)
                    r.reply_code = RPL_OFF;
                else
                begin
                    busy     = 1'b1;
                    tgt_addr = op.addr;
                    wr_left  = op.tl;
                    wr_cnt   = '0;
                    rd_len   = op.rl;
                    rd_cnt   = '0;
                    if (op.tl != 0)
                        wr_res = OUTC_UNKNOWN;
                    if (op.rl != 0)
                        rd_res = OUTC_UNKNOWN;
                    r.start_action = SA_START;
                    r.reply_code   = RPL_OK;
                end
            end
            CMD_EVENT:
            begin
                case (op.ev)
                    EV_IDLE: ;
                    EV_START, EV_REP_START:
                    begin
                        r.start_action   = SA_CLEAR;
                        r.data_out_valid = 1'b1;
                        r.data_out       = {tgt_addr[7:1], wr_left == 0};
                    end
                    EV_SLAW_ACK:
                    begin
                        send_next_tx(r);
                        r.ack_action = ACK_ON;
                    end
                    EV_DATAW_ACK:
                    begin
                        if (wr_cnt < wr_left && wr_cnt < BUFFER_DEPTH)
                            send_next_tx(r);
                        else
                        begin
                            // write phase done: turn around into the read or stop
                            if (rd_cnt == 0 && rd_len > 0)
                                r.start_action = SA_START;
                            else
                            begin
                                r.stop_request = 1'b1;
                                busy           = 1'b0;
                            end
                            wr_left = '0;
                            wr_res  = OUTC_OK;
                        end
                        r.ack_action = ACK_ON;
                    end
                    EV_SLAW_NACK, EV_DATAW_NACK:
                    begin
                        r.stop_request = 1'b1;
                        r.ack_action   = ACK_ON;
                        busy           = 1'b0;
                        wr_left        = '0;
                        wr_res         = OUTC_FAIL;
                    end
                    EV_ARB_LOST:
                    begin
                        r.start_action = SA_START;
                        r.ack_action   = ACK_ON;
                        busy           = 1'b0;
                    end
                    EV_DATAR_ACK, EV_SLAR_ACK:
                    begin
                        if (op.ev == EV_DATAR_ACK)
                            deliver_rx(op.dbyte, r);
                        r.ack_action = (int'(rd_cnt) + 1 < int'(rd_len)) ? ACK_ON : ACK_OFF;
                    end
                    EV_DATAR_NACK:
                    begin
                        deliver_rx(op.dbyte, r);
                        r.stop_request = 1'b1;
                        r.ack_action   = ACK_ON;
                        busy           = 1'b0;
                        rd_res         = OUTC_OK;
                    end
                    EV_SLAR_NACK:
                    begin
                        r.stop_request = 1'b1;
                        r.ack_action   = ACK_ON;
                        busy           = 1'b0;
                        rd_res         = OUTC_FAIL;
                    end
                    default:
                    begin
                        r.stop_request = 1'b1;
                        r.ack_action   = ACK_ON;
                        busy           = 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
        r.busy_res   = busy;
        r.tx_outcome = wr_res;
        r.rx_outcome = rd_res;
        return r;
    endfunction

    // Buffer slot that this beat would send without it ever being loaded
    function automatic int unloaded_slot(input xfer_op_t op);
        if (op.cmd == CMD_EVENT && (op.ev == EV_SLAW_ACK || op.ev == EV_DATAW_ACK) &&
            wr_cnt < wr_left && wr_cnt < BUFFER_DEPTH && !tx_written[wr_cnt[IDX_W-1:0]])
            return int'(wr_cnt);
        return -1;
    endfunction

    function automatic res_t plain_beat(input reply_t rc, input start_act_t sa,
                                        input logic bsy);
        res_t r;
        r              = '0;
        r.reply_code   = rc;
        r.start_action = sa;
        r.busy_res     = bsy;
        return r;
    endfunction

    function automatic void step(input cmd_t c, input logic [IDX_W-1:0] idx,
                                 input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] a,
                                 input logic [LEN_W-1:0] tl, input logic [LEN_W-1:0] rl,
                                 input logic [EV_W-1:0] ev, input bus_req_t bus,
                                 input logic typed, input res_t want);
        plan_row_t row;
        row.op    = '{cmd: c, idx: idx, dbyte: b, addr: a, tl: tl, rl: rl, ev: ev};
        row.bus   = bus;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    function automatic xfer_op_t rand_op(input cmd_t c);
        xfer_op_t op;
        op.cmd   = c;
        op.idx   = IDX_W'($urandom_range(0, 15));
        op.dbyte = BYTE_W'($urandom_range(0, 255));
        op.addr  = BYTE_W'($urandom_range(0, 255));
        op.tl    = LEN_W'($urandom_range(0, 31));
        op.rl    = LEN_W'($urandom_range(0, 31));
        op.ev    = EV_W'($urandom_range(0, 15));
        return op;
    endfunction

    // Status beat with random payload; now and then swap in any other status
    function automatic xfer_op_t event_beat(input logic [EV_W-1:0] e);
        xfer_op_t op;
        op = rand_op(CMD_EVENT);
        if ($urandom_range(0, 99) >= 6)
            op.ev = e;
        return op;
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 16);
        return $urandom_range(0, 4);
    endfunction

    // Present one beat, wait for the handshake, then record its expectation
    task automatic send_beat(input xfer_op_t op, input logic typed, input res_t want);
        res_t pred;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-34){1'b0}}, op.ev, op.rl, op.tl, op.addr, op.dbyte, op.idx};
        s_tuser  <= op.cmd;
        do
            @(posedge clk);
        while (!s_tready);
        pred = predict_beat(op);
        result_q.push_back(typed ? want : pred);
        beats_sent++;
        if (op.cmd == CMD_START && pred.reply_code == RPL_OK)
            starts_ok++;
        if (pred.rx_valid)
            rx_delivered++;
    endtask

    // Load any buffer slot this beat would read before it was ever written
    task automatic push_op(input xfer_op_t op, input logic typed = 1'b0,
                           input res_t want = '0);
        xfer_op_t fill;
        int       slot;
        slot = unloaded_slot(op);
        if (slot >= 0)
        begin
            fill     = rand_op(CMD_LOAD);
            fill.idx = IDX_W'(slot);
            send_beat(fill, 1'b0, '0);
        end
        send_beat(op, typed, want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_bus_enable(input bit v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        bus_on = v;
    endtask

    // One mostly well-formed transfer: loads, start, then the status flow
    task automatic run_transfer();
        xfer_op_t op;
        int       tl;
        int       rl;
        tl = pick_len();
        rl = pick_len();
        if (tl == 0 && rl == 0)
        begin
            if ($urandom_range(0, 1) == 1)
                tl = 1;
            else
                rl = 1;
        end
        for (int i = 0; i < tl; i++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                op     = rand_op(CMD_LOAD);
                op.idx = IDX_W'(i);
                push_op(op);
            end
        end
        op    = rand_op(CMD_START);
        op.tl = LEN_W'(tl);
        op.rl = LEN_W'(rl);
        if ($urandom_range(0, 19) == 0)
            op.rl = LEN_W'($urandom_range(17, 31));
        push_op(op);
        push_op(event_beat(EV_START));
        if (tl > 0)
        begin
            push_op(event_beat(EV_SLAW_ACK));
            repeat (tl)
                push_op(event_beat(EV_DATAW_ACK));
        end
        if (rl > 0)
        begin
            if (tl > 0)
                push_op(event_beat(EV_REP_START));
            push_op(event_beat(EV_SLAR_ACK));
            // occasionally read one byte past the requested length
            repeat (rl - 1 + int'($urandom_range(0, 7) == 0))
                push_op(event_beat(EV_DATAR_ACK));
            push_op(event_beat(EV_DATAR_NACK));
        end
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct, input bit bus,
                             input int n_beats);
        int first;
        write_bus_enable(bus);
        src_idle_pct   = src_pct;
        sink_stall_pct <= sink_pct;
        first = beats_sent;
        while (beats_sent - first < n_beats)
        begin
            // noise between transfers
            repeat ($urandom_range(0, 2))
                push_op(rand_op(cmd_t'($urandom_range(0, 3))));
            run_transfer();
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (result_q.size() == 0)
            begin
                $error("result beat with no expectation pending: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = result_q.pop_front();
                check_field("reply_code",     8'(want.reply_code),     8'(m_tdata[1:0]));
                check_field("data_out_valid", 8'(want.data_out_valid), 8'(m_tdata[2]));
                check_field("data_out",       want.data_out,           m_tdata[10:3]);
                check_field("start_action",   8'(want.start_action),   8'(m_tdata[12:11]));
                check_field("stop_request",   8'(want.stop_request),   8'(m_tdata[13]));
                check_field("ack_action",     8'(want.ack_action),     8'(m_tdata[15:14]));
                check_field("rx_valid",       8'(want.rx_valid),       8'(m_tdata[16]));
                check_field("rx_byte",        want.rx_byte,            m_tdata[24:17]);
                check_field("rx_index",       8'(want.rx_index),       8'(m_tdata[28:25]));
                check_field("busy_res",       8'(want.busy_res),       8'(m_tdata[29]));
                check_field("tx_outcome",     8'(want.tx_outcome),     8'(m_tdata[31:30]));
                check_field("rx_outcome",     8'(want.rx_outcome),     8'(m_tdata[33:32]));
            end
        end
    end

    // Abort when neither stream moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        // Directed beats: reset state, length, enable and busy errors, then one
        // write-then-read, a read-only and a write-only transfer
        step(CMD_NOP,   4'hF, 8'hFF, 8'hFF, 5'h1F, 5'h1F, 4'hF, BUS_KEEP, 1'b1,
             plain_beat(RPL_OK, SA_NONE, 1'b0));
        step(CMD_START, 4'h0, 8'h00, 8'hFF, 5'd16, 5'd16, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_OFF, SA_NONE, 1'b0));
        step(CMD_START, 4'h0, 8'h00, 8'h10, 5'd0, 5'd0, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_BAD_LEN, SA_NONE, 1'b0));
        step(CMD_START, 4'h0, 8'h00, 8'h10, 5'd17, 5'd1, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_BAD_LEN, SA_NONE, 1'b0));
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_OK, SA_NONE, 1'b0));
        step(CMD_LOAD,  4'h0, 8'hA5, 8'h00, 5'd0, 5'd0, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_OK, SA_NONE, 1'b0));
        step(CMD_LOAD,  4'hF, 8'hFF, 8'h00, 5'd0, 5'd0, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_OK, SA_NONE, 1'b0));
        step(CMD_LOAD,  4'h1, 8'h00, 8'h00, 5'd0, 5'd0, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_OK, SA_NONE, 1'b0));
        step(CMD_START, 4'h0, 8'h00, 8'hA1, 5'd2, 5'd1, EV_IDLE, BUS_ON, 1'b1,
             plain_beat(RPL_OK, SA_START, 1'b1));
        step(CMD_START, 4'h0, 8'h00, 8'h00, 5'd1, 5'd0, EV_IDLE, BUS_KEEP, 1'b1,
             plain_beat(RPL_BUSY, SA_NONE, 1'b1));
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_START,      BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_SLAW_ACK,   BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_DATAW_ACK,  BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_DATAW_ACK,  BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_REP_START,  BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_SLAR_ACK,   BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h5A, 8'h00, 5'd0, 5'd0, EV_DATAR_NACK, BUS_KEEP, 1'b0, '0);
        step(CMD_START, 4'h0, 8'h00, 8'h00, 5'd0, 5'd2, EV_IDLE,       BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_SLAW_ACK,   BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'hFF, 8'h00, 5'd0, 5'd0, EV_DATAR_ACK,  BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_DATAR_ACK,  BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h33, 8'h00, 5'd0, 5'd0, EV_DATAR_ACK,  BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_SLAR_NACK,  BUS_KEEP, 1'b0, '0);
        step(CMD_START, 4'h0, 8'h00, 8'h7E, 5'd1, 5'd0, EV_IDLE,       BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_DATAW_NACK, BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, EV_ARB_LOST,   BUS_KEEP, 1'b0, '0);
        step(CMD_EVENT, 4'h0, 8'h00, 8'h00, 5'd0, 5'd0, 4'hF,          BUS_KEEP, 1'b0, '0);

        // Hold reset, then release on a clock edge
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table without idling
        foreach (plan[i])
        begin
            if (plan[i].bus != BUS_KEEP)
                write_bus_enable(plan[i].bus == BUS_ON);
            push_op(plan[i].op, plan[i].typed, plan[i].want);
        end

        // Random transfers under each idle and stall mix
        run_phase(0,  0,  1'b1, 150);
        run_phase(61, 0,  1'b1, 110);
        run_phase(0,  61, 1'b0, 40);
        run_phase(0,  61, 1'b1, 90);
        run_phase(26, 26, 1'b1, 110);

        // Drain, then give the pipeline time to show any extra beat
        drain_results();
        repeat (8)
            @(posedge clk);
        if (result_q.size() != 0)
        begin
            $error("%0d expected result beats never arrived", result_q.size());
            fail_count++;
        end

        $display("Sent %0d input beats: %0d transfers started, %0d read bytes delivered.",
                 beats_sent, starts_ok, rx_delivered);
        $display("Compared %0d result beats across five idle/stall mixes, bus enable on and off.",
                 results_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ i2c_master_transfer_sequencer.f @@
rtl/i2cms_pkg.sv
rtl/i2cms_front.sv
rtl/i2cms_queue.sv
rtl/i2cms_back.sv
rtl/i2c_master_transfer_sequencer.sv
sim/tb.sv
